// File: hdl/cpes_pkg.sv
// ----------------------------------------------------------------------------
// cpes_pkg
// Shared types and constants for the five-population Euler step block.
// ----------------------------------------------------------------------------
package cpes_pkg;

    localparam int CntW = 48;
    localparam int WideW = 64;
    localparam logic signed [WideW-1:0] Lim = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WideW-1:0] C48Max = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [WideW-1:0] C48Min = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

    localparam logic [2:0] RegMaxGrowth = 3'd0;
    localparam logic [2:0] RegUptake = 3'd1;
    localparam logic [2:0] RegBind = 3'd2;
    localparam logic [2:0] RegAntibody = 3'd3;
    localparam logic [2:0] RegExhaust = 3'd4;
    localparam logic [2:0] RegInitFree = 3'd5;

    typedef struct packed {
        logic        command;
        logic [31:0] step_size;
        logic [46:0] max_cells;
        logic [46:0] total_cells;
        logic [31:0] antigen_level;
        logic [31:0] antibody_level;
        logic [46:0] partner_free;
        logic [46:0] presenter_loaded;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] free_out;
        logic signed [47:0] loaded_out;
        logic signed [47:0] bound_out;
        logic signed [47:0] blocked_out;
        logic signed [47:0] exhausted_out;
        logic signed [47:0] total_out;
    } t_out_item;

    // shared multiplier request / response
    typedef struct packed {
        logic                    start;
        logic signed [WideW-1:0] a;
        logic signed [WideW-1:0] b;
        logic                    sh24;
    } t_mul_req;

    typedef struct packed {
        logic                    done;
        logic signed [WideW-1:0] p;
    } t_mul_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RUN,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_MUL,
        MS_ACC
    } t_mstate;

    function automatic logic signed [WideW-1:0] clampw(input logic signed [WideW:0] v);
        logic signed [WideW:0] lp;
        lp = {Lim[WideW-1], Lim};
        if (v > lp) return Lim;
        if (v < -lp) return -Lim;
        return v[WideW-1:0];
    endfunction

    function automatic logic signed [WideW-1:0] clamp48(input logic signed [WideW-1:0] v);
        if (v > C48Max) return C48Max;
        if (v < C48Min) return C48Min;
        return v;
    endfunction

endpackage

// File: hdl/cpes_mul.sv
// ----------------------------------------------------------------------------
// cpes_mul
// Shared signed multiplier: 64x64 magnitude product from four 32x32 partial
// products, each taken through a multiply and an accumulate step after a load
// step, shifted by 16 or 24, truncated and clamped.
// ----------------------------------------------------------------------------
module cpes_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cpes_pkg::t_mul_req i_req,
    output cpes_pkg::t_mul_rsp o_rsp
);

    logic [63:0]  r_ma, r_mb;
    logic         r_neg, r_sh24;
    logic [127:0] r_acc;
    logic [1:0]   r_k;
    logic [63:0]  r_pp;
    cpes_pkg::t_mstate r_st, n_st;
    logic         r_done;

    logic [31:0]  w_ao, w_bo;
    logic [63:0]  w_pp;
    logic [127:0] w_sh;
    logic [63:0]  w_mag;
    logic [63:0]  w_abs_a, w_abs_b;
    logic [6:0]   w_pos;

    assign w_abs_a = i_req.a[63] ? 64'(-i_req.a) : i_req.a;
    assign w_abs_b = i_req.b[63] ? 64'(-i_req.b) : i_req.b;
    assign w_ao = r_k[0] ? r_ma[63:32] : r_ma[31:0];
    assign w_bo = r_k[1] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp = w_ao * w_bo;
    assign w_pos = ({6'd0, r_k[0]} + {6'd0, r_k[1]}) * 7'd32;
    assign w_sh = r_sh24 ? (r_acc >> 24) : (r_acc >> 16);
    assign w_mag = (w_sh[127:64] != 64'd0 || w_sh[63:0] > 64'(cpes_pkg::Lim))
                   ? 64'(cpes_pkg::Lim) : w_sh[63:0];

    always_comb begin
        n_st = r_st;
        case (r_st)
            cpes_pkg::MS_IDLE: if (i_req.start) n_st = cpes_pkg::MS_MUL;
            cpes_pkg::MS_MUL:  n_st = cpes_pkg::MS_ACC;
            cpes_pkg::MS_ACC:  n_st = (r_k == 2'd3) ? cpes_pkg::MS_IDLE : cpes_pkg::MS_MUL;
            default:           n_st = cpes_pkg::MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= cpes_pkg::MS_IDLE;
            r_done <= 1'b0;
            r_k    <= 2'd0;
        end else begin
            r_st   <= n_st;
            r_done <= 1'b0;
            case (r_st)
                cpes_pkg::MS_IDLE: begin
                    r_k <= 2'd0;
                end
                cpes_pkg::MS_ACC: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) r_done <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            cpes_pkg::MS_IDLE: begin
                r_ma   <= w_abs_a;
                r_mb   <= w_abs_b;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_sh24 <= i_req.sh24;
                r_acc  <= '0;
            end
            cpes_pkg::MS_MUL: r_pp <= w_pp;
            cpes_pkg::MS_ACC: begin
                r_acc <= r_acc + ({64'd0, r_pp} << w_pos);
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p = r_neg ? -$signed(w_mag) : $signed(w_mag);

    property p_done_pulse;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done;
    endproperty
    a_done_pulse: assert property (p_done_pulse) else $error("done held");

    property p_done_from_acc;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_done |-> $past(r_st) == cpes_pkg::MS_ACC;
    endproperty
    a_done_from_acc: assert property (p_done_from_acc) else $error("stray done");

    property p_done_after_last;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_st == cpes_pkg::MS_ACC && r_k == 2'd3) |=> r_done;
    endproperty
    a_done_after_last: assert property (p_done_after_last) else $error("missing done");

endmodule

// File: hdl/cpes_div.sv
// ----------------------------------------------------------------------------
// cpes_div
// Restoring divider for the growth ratio, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpes_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [46:0]        i_maxc,
    input  logic [46:0]        i_tot,
    output logic               o_done,
    output logic signed [63:0] o_ratio
);

    // quotient has up to 47 integer and 24 fraction bits
    localparam int QW = 71;

    logic              r_busy, r_done, r_neg, r_zero;
    logic [6:0]        r_cnt;
    logic [QW-1:0]     r_num;
    logic [47:0]       r_rem;
    logic [46:0]       r_m;
    logic [QW-1:0]     r_q;

    logic [47:0]       w_trial;
    logic [47:0]       w_diff;
    logic              w_ge;
    logic signed [47:0] w_d;
    logic [46:0]       w_mag;
    logic [63:0]       w_r;

    assign w_d = $signed({1'b0, i_maxc}) - $signed({1'b0, i_tot});
    assign w_mag = w_d[47] ? 47'(-w_d) : w_d[46:0];
    assign w_trial = {r_rem[46:0], r_num[QW-1]};
    assign w_ge = w_trial >= {1'b0, r_m};
    assign w_diff = w_trial - {1'b0, r_m};
    assign w_r = (r_zero) ? 64'd0 :
                 (r_q[QW-1:24] >= 47'(64'd1 << 38)) ? 64'(cpes_pkg::Lim) :
                 64'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_num  <= {w_mag, 24'd0};
            r_rem  <= '0;
            r_m    <= i_maxc;
            r_q    <= '0;
            r_neg  <= w_d[47];
            r_zero <= (i_maxc == 47'd0);
        end else if (r_busy) begin
            r_num <= {r_num[QW-2:0], 1'b0};
            r_rem <= w_ge ? w_diff : w_trial;
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_ratio = r_neg ? -$signed(w_r) : $signed(w_r);

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> $past(r_busy);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("div done");

    property p_rem_below;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_busy && r_m != 47'd0) |-> r_rem < {1'b0, r_m};
    endproperty
    a_rem_below: assert property (p_rem_below) else $error("div remainder");

    property p_busy_count;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> r_cnt != 7'd0;
    endproperty
    a_busy_count: assert property (p_busy_count) else $error("div count");

endmodule

// File: hdl/cell_population_euler_step.sv
// ----------------------------------------------------------------------------
// cell_population_euler_step
// One explicit Euler step over five cell counts, sequenced through one
// shared multiplier and a bit-serial divider.
//
//   channel | direction | handshake          | payload
//   in      | in        | i_in_valid/o_in_ready   | cpes_pkg::t_in_item
//   out     | out       | o_out_valid/i_out_ready | cpes_pkg::t_out_item
//   cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// a reload item goes straight to the output; an advance item runs the division
// and then 26 multiplies in turn on the shared multiplier before the hand-off
// the block takes one item at a time, ready is low until the result is taken
// synchronous active-low reset clears the counts and registers
// a stalled output holds its item; configuration is always accepted
// ----------------------------------------------------------------------------
module cell_population_euler_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cpes_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cpes_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    typedef logic signed [63:0] t_w;

    // micro-op: dst = clamp(acc op mul(a,b,sh)) is done as sequenced steps
    cpes_pkg::t_state r_st, n_st;
    logic [31:0] r_rg, r_ru, r_rb, r_ra, r_re;
    logic [46:0] r_init;
    t_w r_f, r_l, r_b, r_k, r_x;
    cpes_pkg::t_in_item r_in;
    t_w r_t [0:14];
    logic [5:0] r_pc;
    logic r_mstart;
    cpes_pkg::t_out_item r_out;
    logic r_ovalid;

    cpes_pkg::t_mul_req w_req;
    cpes_pkg::t_mul_rsp w_rsp;
    logic w_ddone;
    t_w w_ratio;
    logic w_dstart;

    // temporaries
    localparam logic [3:0] TG = 4'd0, TU = 4'd1, TAB = 4'd2, TBL = 4'd3, TBA = 4'd4,
                           TGE = 4'd5, TE = 4'd6, TR = 4'd7, TNF = 4'd8, TNL = 4'd9,
                           TNB = 4'd10, TNK = 4'd11, TACC = 4'd12, TRAT = 4'd13,
                           TS = 4'd14;

    // program: op kinds
    // 0: t[d]=mul(a,b,sh)  1: t[d]=clamp48(t[ACC]+mul), or t[ACC]+=mul if d=ACC
    t_w w_a, w_b;
    logic w_sh;
    logic [3:0] w_dst;
    logic [1:0] w_kind; // 0 write, 1 acc add
    logic w_last;

    function automatic t_w u32(input logic [31:0] v);
        return t_w'({32'd0, v});
    endfunction
    function automatic t_w u47(input logic [46:0] v);
        return t_w'({17'd0, v});
    endfunction
    function automatic t_w addc(input t_w a, input t_w b);
        return cpes_pkg::clampw(65'(a) + 65'(b));
    endfunction
    function automatic t_w subc(input t_w a, input t_w b);
        return cpes_pkg::clampw(65'(a) - 65'(b));
    endfunction

    always_comb begin
        w_a = '0; w_b = '0; w_sh = 1'b0; w_dst = 4'(TE); w_kind = 2'd0; w_last = 1'b0;
        case (r_pc)
            6'd0:  begin w_a = r_t[TRAT]; w_b = u32(r_rg); w_sh = 1'b1; w_dst = 4'(TG); end
            6'd1:  begin w_a = u32(r_ru); w_b = u32(r_in.antigen_level); w_dst = 4'(TU); end
            6'd2:  begin w_a = u32(r_ra); w_b = u32(r_in.antibody_level); w_dst = 4'(TAB); end
            6'd3:  begin w_a = u32(r_rb); w_b = u47(r_in.partner_free); w_dst = 4'(TBL); end
            6'd4:  begin w_a = u32(r_rb); w_b = u47(r_in.presenter_loaded); w_dst = 4'(TBA); end
            // free: e = mul(sub(g,u), step); acc = f + mul(f, e)
            6'd5:  begin w_a = subc(r_t[TG], r_t[TU]); w_b = u32(r_in.step_size);
                         w_sh = 1'b1; w_dst = 4'(TE); end
            6'd6:  begin w_a = r_f; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TNF); end
            // loaded
            6'd7:  begin w_a = u32(r_rb); w_b = r_l; w_dst = 4'(TR); end
            6'd8:  begin w_a = r_t[TU]; w_b = u32(r_in.step_size); w_sh = 1'b1;
                         w_dst = 4'(TE); end
            6'd9:  begin w_a = r_t[TNF]; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TACC); end
            6'd10: begin w_a = subc(subc(r_t[TS], r_t[TR]), r_t[TAB]);
                         w_b = u32(r_in.step_size); w_sh = 1'b1; w_dst = 4'(TE); end
            6'd11: begin w_a = r_l; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TNL); end
            // bound
            6'd12: begin w_a = u32(r_rb); w_b = r_t[TNL]; w_dst = 4'(TR); end
            6'd13: begin w_a = r_t[TGE]; w_b = u32(r_in.step_size); w_sh = 1'b1;
                         w_dst = 4'(TE); end
            6'd14: begin w_a = r_b; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TACC); end
            6'd15: begin w_a = addc(addc(r_t[TBL], r_t[TBA]), r_t[TR]);
                         w_b = u32(r_in.step_size); w_sh = 1'b1; w_dst = 4'(TE); end
            6'd16: begin w_a = r_t[TNL]; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TNB); end
            // blocked
            6'd17: begin w_a = r_t[TAB]; w_b = u32(r_in.step_size); w_sh = 1'b1;
                         w_dst = 4'(TE); end
            6'd18: begin w_a = r_t[TNL]; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TACC); end
            6'd19: begin w_a = r_t[TGE]; w_b = u32(r_in.step_size); w_sh = 1'b1;
                         w_dst = 4'(TE); end
            6'd20: begin w_a = r_k; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TNK); end
            // exhausted
            6'd21: begin w_a = r_t[TG]; w_b = u32(r_in.step_size); w_sh = 1'b1;
                         w_dst = 4'(TE); end
            6'd22: begin w_a = r_x; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TACC); end
            6'd23: begin w_a = u32(r_re); w_b = u32(r_in.step_size); w_sh = 1'b1;
                         w_dst = 4'(TE); end
            6'd24: begin w_a = r_t[TNB]; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TACC); end
            6'd25: begin w_a = r_t[TNK]; w_b = r_t[TE]; w_sh = 1'b1; w_kind = 2'd1;
                         w_dst = 4'(TACC); w_last = 1'b1; end
            default: ;
        endcase
    end

    assign w_req.start = r_mstart;
    assign w_req.a = w_a;
    assign w_req.b = w_b;
    assign w_req.sh24 = w_sh;

    assign w_dstart = (r_st == cpes_pkg::ST_IDLE) && i_in_valid && !i_in_item.command;

    cpes_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));
    cpes_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
                    .i_maxc(i_in_item.max_cells), .i_tot(i_in_item.total_cells),
                    .o_done(w_ddone), .o_ratio(w_ratio));

    always_comb begin
        n_st = r_st;
        case (r_st)
            cpes_pkg::ST_IDLE: if (i_in_valid) n_st = i_in_item.command ? cpes_pkg::ST_OUT
                                                                        : cpes_pkg::ST_DIV;
            cpes_pkg::ST_DIV:  if (w_ddone) n_st = cpes_pkg::ST_RUN;
            cpes_pkg::ST_RUN:  n_st = cpes_pkg::ST_WAIT;
            cpes_pkg::ST_WAIT: if (w_rsp.done) n_st = w_last ? cpes_pkg::ST_OUT
                                                             : cpes_pkg::ST_RUN;
            cpes_pkg::ST_OUT:  if (r_ovalid && i_out_ready) n_st = cpes_pkg::ST_IDLE;
            default:           n_st = cpes_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_st == cpes_pkg::ST_IDLE);
        o_cfg_ready = 1'b1;
        o_out_valid = r_ovalid;
        o_out_item = r_out;
    end

    t_w w_nx, w_sum, w_tot;
    assign w_nx = cpes_pkg::clamp48(addc(r_t[TACC], w_rsp.p));
    assign w_sum = r_f + r_l + r_b + r_x;
    assign w_tot = cpes_pkg::clamp48(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= cpes_pkg::ST_IDLE;
            r_rg <= '0; r_ru <= '0; r_rb <= '0; r_ra <= '0; r_re <= '0; r_init <= '0;
            r_f <= '0; r_l <= '0; r_b <= '0; r_k <= '0; r_x <= '0;
            r_pc <= '0; r_mstart <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            r_mstart <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cpes_pkg::RegMaxGrowth: r_rg <= i_cfg_data[31:0];
                    cpes_pkg::RegUptake:    r_ru <= i_cfg_data[31:0];
                    cpes_pkg::RegBind:      r_rb <= i_cfg_data[31:0];
                    cpes_pkg::RegAntibody:  r_ra <= i_cfg_data[31:0];
                    cpes_pkg::RegExhaust:   r_re <= i_cfg_data[31:0];
                    cpes_pkg::RegInitFree:  r_init <= i_cfg_data[46:0];
                    default: ;
                endcase
            end
            case (r_st)
                cpes_pkg::ST_IDLE: begin
                    r_pc <= '0;
                    if (i_in_valid && i_in_item.command) begin
                        r_f <= u47(r_init); r_l <= '0; r_b <= '0; r_k <= '0; r_x <= '0;
                    end
                end
                cpes_pkg::ST_DIV: if (w_ddone) r_mstart <= 1'b1;
                cpes_pkg::ST_WAIT: if (w_rsp.done) begin
                    r_pc <= r_pc + 6'd1;
                    if (!w_last) r_mstart <= 1'b1;
                    if (w_last) begin
                        r_f <= r_t[TNF]; r_l <= r_t[TNL]; r_b <= r_t[TNB];
                        r_k <= r_t[TNK]; r_x <= w_nx;
                    end
                end
                cpes_pkg::ST_OUT: begin
                    if (!r_ovalid) r_ovalid <= 1'b1;
                    else if (i_out_ready) r_ovalid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == cpes_pkg::ST_IDLE && i_in_valid) r_in <= i_in_item;
        if (r_st == cpes_pkg::ST_DIV && w_ddone) begin
            r_t[TRAT] <= w_ratio;
        end
        if (r_st == cpes_pkg::ST_RUN && r_pc == 6'd6) begin
            r_t[TGE] <= subc(r_t[TG], u32(r_re));
            r_t[TS] <= subc(subc(r_t[TG], r_t[TBL]), r_t[TBA]);
        end
        if (r_st == cpes_pkg::ST_RUN && (r_pc == 6'd9 || r_pc == 6'd14 || r_pc == 6'd18 ||
                                         r_pc == 6'd22)) begin
            r_t[TACC] <= (r_pc == 6'd9) ? r_l : (r_pc == 6'd14) ? r_b :
                         (r_pc == 6'd18) ? r_k : r_x;
        end
        if (r_st == cpes_pkg::ST_RUN && r_pc == 6'd6) r_t[TACC] <= r_f;
        if (r_st == cpes_pkg::ST_WAIT && w_rsp.done) begin
            if (w_kind == 2'd1) begin
                if (w_dst == 4'(TACC)) r_t[TACC] <= addc(r_t[TACC], w_rsp.p);
                else r_t[w_dst] <= w_nx;
            end else begin
                r_t[w_dst] <= w_rsp.p;
            end
        end
        if (r_st == cpes_pkg::ST_OUT && !r_ovalid) begin
            r_out.free_out      <= r_f[47:0];
            r_out.loaded_out    <= r_l[47:0];
            r_out.bound_out     <= r_b[47:0];
            r_out.blocked_out   <= r_k[47:0];
            r_out.exhausted_out <= r_x[47:0];
            r_out.total_out     <= w_tot[47:0];
        end
    end

    property p_out_only_in_out;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_ovalid |-> r_st == cpes_pkg::ST_OUT;
    endproperty
    a_out_only_in_out: assert property (p_out_only_in_out) else $error("stray output");

    property p_no_accept_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_st != cpes_pkg::ST_IDLE) |-> !o_in_ready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_pc_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_pc <= 6'd26;
    endproperty
    a_pc_bound: assert property (p_pc_bound) else $error("program counter");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-population Euler step block. A bit-exact
// fixed-point predictor runs beside the block and every result item is
// checked field by field against it. The run goes through four register
// settings with directed and random items, and varies idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic CmdAdvance = 1'b0;
    localparam logic CmdReload = 1'b1;
    localparam logic [2:0] RegSpareLo = 3'd6;
    localparam logic [2:0] RegSpareHi = 3'd7;
    localparam int PhaseItems = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    cpes_pkg::t_in_item   i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    cpes_pkg::t_out_item  o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_index = '0;
    logic [63:0]          i_cfg_data = '0;

    cell_population_euler_step u_top (.*);

    always #10 i_clk = ~i_clk;

    // predictor state and register shadow
    logic signed [63:0] cnt_free, cnt_loaded, cnt_bound, cnt_blocked, cnt_exh;
    logic [31:0] rate_growth, rate_uptake, rate_bind, rate_antibody, rate_exhaust;
    logic [46:0] reload_free;

    cpes_pkg::t_in_item  pending_items[$];
    cpes_pkg::t_out_item expected_counts[$];
    int issued = 0, accepted = 0, checked = 0, errors = 0, reloads = 0;
    int send_idle_pct = 9, recv_stall_pct = 85;

    function automatic logic signed [63:0] clip62(logic signed [63:0] v);
        if (v > cpes_pkg::Lim) return cpes_pkg::Lim;
        if (v < -cpes_pkg::Lim) return -cpes_pkg::Lim;
        return v;
    endfunction

    function automatic logic signed [63:0] sat48(logic signed [63:0] v);
        if (v > cpes_pkg::C48Max) return cpes_pkg::C48Max;
        if (v < cpes_pkg::C48Min) return cpes_pkg::C48Min;
        return v;
    endfunction

    function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                  logic signed [63:0] b, int sh);
        logic neg;
        logic [63:0] ma, mb, r;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = ({64'd0, ma} * {64'd0, mb}) >> sh;
        r = (p > 128'(cpes_pkg::Lim)) ? cpes_pkg::Lim : p[63:0];
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] euler_term(logic signed [63:0] cnt,
            logic signed [63:0] rate, logic signed [63:0] dt);
        return fx_mul(cnt, fx_mul(rate, dt, 24), 24);
    endfunction

    function automatic logic signed [63:0] growth_ratio(logic [46:0] cap, logic [46:0] tot);
        logic signed [63:0] diff, r;
        logic [63:0] m, mag, q, rem;
        logic [127:0] f;
        if (cap == 0) return 0;
        diff = $signed({17'd0, cap}) - $signed({17'd0, tot});
        m = {17'd0, cap};
        mag = (diff < 0) ? -diff : diff;
        q = mag / m;
        rem = mag % m;
        if (q >= (64'd1 << 38)) begin
            r = cpes_pkg::Lim;
        end else begin
            f = ({64'd0, rem} << 24) / {64'd0, m};
            r = $signed((q << 24) | f[63:0]);
        end
        return (diff < 0) ? -r : r;
    endfunction

    task automatic predict_step(input cpes_pkg::t_in_item it,
                                output cpes_pkg::t_out_item res);
        logic signed [63:0] dt, g, u, ab, bl, ba, bnd, exh, ge, rl, rb;
        logic signed [63:0] nf, nl, nb, nk, nx, tot;
        if (it.command == CmdReload) begin
            cnt_free = {17'd0, reload_free};
            cnt_loaded = 0; cnt_bound = 0; cnt_blocked = 0; cnt_exh = 0;
        end else begin
            dt = {32'd0, it.step_size};
            bnd = {32'd0, rate_bind};
            exh = {32'd0, rate_exhaust};
            g = fx_mul(growth_ratio(it.max_cells, it.total_cells), {32'd0, rate_growth}, 24);
            u = fx_mul({32'd0, rate_uptake}, {32'd0, it.antigen_level}, 16);
            ab = fx_mul({32'd0, rate_antibody}, {32'd0, it.antibody_level}, 16);
            bl = fx_mul(bnd, {17'd0, it.partner_free}, 16);
            ba = fx_mul(bnd, {17'd0, it.presenter_loaded}, 16);
            ge = clip62(g - exh);
            nf = sat48(clip62(cnt_free + euler_term(cnt_free, clip62(g - u), dt)));
            rl = clip62(clip62(clip62(clip62(g - bl) - ba) - fx_mul(bnd, cnt_loaded, 16)) - ab);
            nl = sat48(clip62(clip62(cnt_loaded + euler_term(nf, u, dt))
                              + euler_term(cnt_loaded, rl, dt)));
            rb = clip62(clip62(bl + ba) + fx_mul(bnd, nl, 16));
            nb = sat48(clip62(clip62(cnt_bound + euler_term(cnt_bound, ge, dt))
                              + euler_term(nl, rb, dt)));
            nk = sat48(clip62(clip62(cnt_blocked + euler_term(nl, ab, dt))
                              + euler_term(cnt_blocked, ge, dt)));
            nx = sat48(clip62(clip62(clip62(cnt_exh + euler_term(cnt_exh, g, dt))
                                     + euler_term(nb, exh, dt)) + euler_term(nk, exh, dt)));
            cnt_free = nf; cnt_loaded = nl; cnt_bound = nb;
            cnt_blocked = nk; cnt_exh = nx;
        end
        tot = sat48(cnt_free + cnt_loaded + cnt_bound + cnt_exh);
        res.free_out = cnt_free[47:0];
        res.loaded_out = cnt_loaded[47:0];
        res.bound_out = cnt_bound[47:0];
        res.blocked_out = cnt_blocked[47:0];
        res.exhausted_out = cnt_exh[47:0];
        res.total_out = tot[47:0];
    endtask

    task automatic report(input string field, input logic [47:0] got, input logic [47:0] exp_v);
        $display("mismatch item %0d %s: got %h expected %h", checked, field, got, exp_v);
        errors++;
    endtask

    // monitor: register shadow, prediction on accepted items, result checks
    always @(posedge i_clk) begin
        cpes_pkg::t_out_item res, want;
        if (!i_rst_n) begin
            cnt_free = 0; cnt_loaded = 0; cnt_bound = 0; cnt_blocked = 0; cnt_exh = 0;
            rate_growth = 0; rate_uptake = 0; rate_bind = 0;
            rate_antibody = 0; rate_exhaust = 0; reload_free = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cpes_pkg::RegMaxGrowth: rate_growth = i_cfg_data[31:0];
                    cpes_pkg::RegUptake: rate_uptake = i_cfg_data[31:0];
                    cpes_pkg::RegBind: rate_bind = i_cfg_data[31:0];
                    cpes_pkg::RegAntibody: rate_antibody = i_cfg_data[31:0];
                    cpes_pkg::RegExhaust: rate_exhaust = i_cfg_data[31:0];
                    cpes_pkg::RegInitFree: reload_free = i_cfg_data[46:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_step(i_in_item, res);
                expected_counts.push_back(res);
                if (i_in_item.command == CmdReload) reloads++;
                accepted++;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_counts.size() == 0) begin
                    report("unexpected", o_out_item.free_out, '0);
                end else begin
                    want = expected_counts.pop_front();
                    if (o_out_item.free_out !== want.free_out)
                        report("free", o_out_item.free_out, want.free_out);
                    if (o_out_item.loaded_out !== want.loaded_out)
                        report("loaded", o_out_item.loaded_out, want.loaded_out);
                    if (o_out_item.bound_out !== want.bound_out)
                        report("bound", o_out_item.bound_out, want.bound_out);
                    if (o_out_item.blocked_out !== want.blocked_out)
                        report("blocked", o_out_item.blocked_out, want.blocked_out);
                    if (o_out_item.exhausted_out !== want.exhausted_out)
                        report("exhausted", o_out_item.exhausted_out, want.exhausted_out);
                    if (o_out_item.total_out !== want.total_out)
                        report("total", o_out_item.total_out, want.total_out);
                end
                checked++;
            end
        end
    end

    // driver and receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (accepted < 533) begin
                send_idle_pct = 9; recv_stall_pct = 85;
            end else if (accepted < 1066) begin
                send_idle_pct = 85; recv_stall_pct = 9;
            end else begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
            if (issued == accepted) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    issued++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [46:0] rand47();
        return 47'({$urandom, $urandom});
    endfunction

    function automatic cpes_pkg::t_in_item make_item(logic cmd, logic [31:0] dt,
            logic [46:0] cap, logic [46:0] tot, logic [31:0] ag, logic [31:0] abl,
            logic [46:0] part, logic [46:0] pres);
        cpes_pkg::t_in_item it;
        it.command = cmd; it.step_size = dt; it.max_cells = cap; it.total_cells = tot;
        it.antigen_level = ag; it.antibody_level = abl;
        it.partner_free = part; it.presenter_loaded = pres;
        return it;
    endfunction

    function automatic cpes_pkg::t_in_item rand_item();
        logic [46:0] cap;
        if ($urandom_range(9) == 0) return make_item(CmdReload, $urandom, rand47(),
                rand47(), $urandom, $urandom, rand47(), rand47());
        if ($urandom_range(9) < 3) return make_item(CmdAdvance, $urandom, rand47(),
                rand47(), $urandom, $urandom, rand47(), rand47());
        cap = {31'($urandom_range(1 << 24)), 16'd0};
        return make_item(CmdAdvance, $urandom_range(1 << 22), cap,
                         cap + 47'($urandom_range(1 << 26)) - 47'(1 << 25),
                         $urandom_range(1 << 18), $urandom_range(1 << 18),
                         47'($urandom_range(1 << 22)), 47'($urandom_range(1 << 22)));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && issued == accepted && expected_counts.size() == 0);
        repeat (300) @(negedge i_clk);
    endtask

    task automatic set_rates(input int mode);
        logic [2:0] r;
        for (int k = 0; k < 6; k++) begin
            r = 3'(k);
            case (mode)
                0: write_reg(r, (r == cpes_pkg::RegInitFree)
                                ? 64'({$urandom_range(1 << 20), 16'd0})
                                : 64'($urandom_range(1 << 20)));
                1: write_reg(r, 64'hFFFF_FFFF_FFFF_FFFF);
                2: write_reg(r, 64'd0);
                default: write_reg(r, {$urandom, $urandom});
            endcase
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            set_rates(ph);
            if (ph == 3) begin
                write_reg(RegSpareLo, {$urandom, $urandom});
                write_reg(RegSpareHi, {$urandom, $urandom});
            end
            if (ph == 0) begin
                pending_items.push_back(make_item(CmdReload, '0, '0, '0, '0, '0, '0, '0));
                // zero capacity
                pending_items.push_back(make_item(CmdAdvance, 32'h0100_0000, '0,
                                                  47'h10_0000, 32'h1_0000, 32'h1_0000,
                                                  47'h1_0000, 47'h1_0000));
                // huge negative ratio then a ratio of exactly one
                pending_items.push_back(make_item(CmdAdvance, 32'h0040_0000, 47'd1, '1,
                                                  32'h1_0000, 32'h1_0000, 47'h1_0000, '0));
                pending_items.push_back(make_item(CmdAdvance, 32'h0040_0000, '1, '0,
                                                  '0, '0, '0, 47'h1_0000));
                pending_items.push_back(make_item(CmdReload, '1, '1, '1, '1, '1, '1, '1));
                pending_items.push_back(make_item(CmdAdvance, '1, '1, '1, '1, '1, '1, '1));
                pending_items.push_back(make_item(CmdAdvance, '0, '1, '0, '1, '1, '1, '1));
                pending_items.push_back(make_item(CmdAdvance, '0, '0, '0, '0, '0, '0, '0));
                pending_items.push_back(make_item(CmdReload, '0, '0, '0, '0, '0, '0, '0));
                for (int k = 0; k < 8; k++)
                    pending_items.push_back(make_item(CmdAdvance, 32'h0020_0000,
                            47'h100_0000, 47'h10_0000 * 47'(k), 32'h2_0000, 32'h1_0000,
                            47'h4_0000, 47'h2_0000));
            end
            for (int k = 0; k < PhaseItems; k++) pending_items.push_back(rand_item());
            drain();
        end
        $display("covered %0d items (%0d reloads), %0d results checked over four register settings",
                 accepted, reloads, checked);
        if (errors == 0 && expected_counts.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("timeout after %0d results", checked);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
